// ===== rtl/thrf_pkg.sv =====
// ----------------------------------------------------------------------------
// thrf_pkg
// Shared types and constants for the timing histogram hit-range finder.
// ----------------------------------------------------------------------------
package thrf_pkg;

    localparam int BIN_COUNT  = 1024;
    localparam int COUNT_BITS = 20;
    localparam int BIN_W      = $clog2(BIN_COUNT);
    localparam int TIME_W     = 16;
    localparam int SENS_W     = 17;
    localparam int OUT_W      = 10;
    localparam int OP_W       = 2;
    localparam int PROD_W     = (COUNT_BITS > 18) ? 2 * COUNT_BITS : COUNT_BITS + 18;
    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(32768);

    typedef enum logic [OP_W-1:0] {
        OP_ADD_A   = 2'd0,
        OP_ADD_B   = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

endpackage

// ===== rtl/timing_histogram_hit_range_finder.sv =====
// ----------------------------------------------------------------------------
// timing_histogram_hit_range_finder
// Two latency histograms in one RAM; peak search and range walk on request.
// ----------------------------------------------------------------------------
// Sample request: accept, then read (S_RMW_RD) and write back (S_RMW_WR).
// Compute request: accept, then a peak sweep over all bins (read, multiply,
//   compare per bin), then per side a walk set-up and a walk out from the peak
//   (same steps per bin), then emit, which waits while the result register is held.
// Clear request and reset: a clearing pass over all BIN_COUNT bins, no requests taken.
// Sensitivity resets to 32768; the result register resets empty.
module timing_histogram_hit_range_finder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [thrf_pkg::OP_W-1:0]           i_opcode,
    input  logic [thrf_pkg::TIME_W-1:0]         i_sample_time,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [thrf_pkg::OUT_W-1:0]          o_range_begin,
    output logic [thrf_pkg::OUT_W-1:0]          o_range_end,
    output logic [thrf_pkg::OUT_W-1:0]          o_peak_bin,
    input  logic                                i_cfg_wr_en,
    input  logic [thrf_pkg::SENS_W-1:0]         i_cfg_wr_data
);

    localparam int C  = thrf_pkg::COUNT_BITS;
    localparam int BW = thrf_pkg::BIN_W;
    localparam int PW = thrf_pkg::PROD_W;
    localparam logic [BW-1:0] TOP_BIN = BW'(thrf_pkg::BIN_COUNT - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RMW_RD, S_RMW_WR,
        S_PK_RD, S_PK_MUL, S_PK_CMP,
        S_LW_START, S_RW_START, S_WK_RD, S_WK_MUL, S_WK_CMP, S_DONE
    } t_state;

    t_state                     r_state;
    logic [BW-1:0]              r_addr;
    logic [BW-1:0]              r_idx;
    logic [BW-1:0]              r_peak;
    logic [BW-1:0]              r_begin;
    logic [BW-1:0]              r_end;
    logic [BW-1:0]              r_hfb;
    logic                       r_seen;
    logic                       r_is_b;
    logic                       r_right;
    logic [thrf_pkg::SENS_W-1:0] r_sens;
    logic [C-1:0]               r_best_a;
    logic [C-1:0]               r_best_b;
    logic [C-1:0]               r_cur_a;
    logic [C-1:0]               r_cur_b;
    logic [PW-1:0]              r_pl;
    logic [PW-1:0]              r_pr;
    logic                       r_bz;
    logic                       r_out_valid;
    logic [thrf_pkg::OUT_W-1:0] r_o_begin;
    logic [thrf_pkg::OUT_W-1:0] r_o_end;
    logic [thrf_pkg::OUT_W-1:0] r_o_peak;

    logic [2*C-1:0] mem [thrf_pkg::BIN_COUNT];
    logic [2*C-1:0] r_rdata;
    logic           mem_we;
    logic [BW-1:0]  mem_wa;
    logic [2*C-1:0] mem_wd;

    logic [C-1:0]   rd_a;
    logic [C-1:0]   rd_b;
    logic [C-1:0]   inc_a;
    logic [C-1:0]   inc_b;
    logic [BW-1:0]  in_bin;
    logic           accept;
    logic           pass;

    assign rd_a = r_rdata[2*C-1:C];
    assign rd_b = r_rdata[C-1:0];
    assign inc_a = (!r_is_b && rd_a != {C{1'b1}}) ? rd_a + C'(1) : rd_a;
    assign inc_b = ( r_is_b && rd_b != {C{1'b1}}) ? rd_b + C'(1) : rd_b;
    assign in_bin = ({1'b0, i_sample_time} > 17'(thrf_pkg::BIN_COUNT - 1)) ?
                    TOP_BIN : i_sample_time[BW-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign pass    = r_bz || (r_pl >= r_pr);

    assign mem_we = (r_state == S_INIT) || (r_state == S_RMW_WR);
    assign mem_wa = (r_state == S_INIT) ? r_idx : r_addr;
    assign mem_wd = (r_state == S_INIT) ? '0 : {inc_a, inc_b};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_hfb       <= '0;
            r_seen      <= 1'b0;
            r_sens      <= thrf_pkg::SENS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sens <= i_cfg_wr_data;
            end
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + BW'(1);
                    if (r_idx == TOP_BIN) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (thrf_pkg::t_opcode'(i_opcode))
                            thrf_pkg::OP_ADD_A, thrf_pkg::OP_ADD_B: begin
                                r_addr  <= in_bin;
                                r_is_b  <= (i_opcode == thrf_pkg::OP_ADD_B);
                                if (!r_seen || in_bin > r_hfb) begin
                                    r_hfb <= in_bin;
                                end
                                r_seen  <= 1'b1;
                                r_state <= S_RMW_RD;
                            end
                            thrf_pkg::OP_COMPUTE: begin
                                r_addr   <= '0;
                                r_idx    <= '0;
                                r_peak   <= '0;
                                r_best_a <= '0;
                                r_best_b <= C'(1);
                                r_state  <= S_PK_RD;
                            end
                            default: begin
                                r_idx   <= '0;
                                r_hfb   <= '0;
                                r_seen  <= 1'b0;
                                r_state <= S_INIT;
                            end
                        endcase
                    end
                end
                S_RMW_RD: r_state <= S_RMW_WR;
                S_RMW_WR: r_state <= S_IDLE;
                S_PK_RD:  r_state <= S_PK_MUL;
                S_PK_MUL: begin
                    r_cur_a <= rd_a;
                    r_cur_b <= rd_b;
                    r_pl    <= PW'(rd_a) * PW'(r_best_b);
                    r_pr    <= PW'(r_best_a) * PW'(rd_b);
                    r_state <= S_PK_CMP;
                end
                S_PK_CMP: begin
                    if (r_pl > r_pr) begin
                        r_best_a <= r_cur_a;
                        r_best_b <= r_cur_b;
                        r_peak   <= r_idx;
                    end
                    if (r_idx == TOP_BIN) begin
                        r_state <= S_LW_START;
                    end else begin
                        r_idx   <= r_idx + BW'(1);
                        r_addr  <= r_idx + BW'(1);
                        r_state <= S_PK_RD;
                    end
                end
                S_LW_START: begin
                    r_right <= 1'b0;
                    if (r_peak == '0) begin
                        r_begin <= '0;
                        r_state <= S_RW_START;
                    end else begin
                        r_idx   <= r_peak;
                        r_addr  <= r_peak;
                        r_state <= S_WK_RD;
                    end
                end
                S_RW_START: begin
                    r_right <= 1'b1;
                    if (r_peak >= r_hfb) begin
                        r_end   <= r_peak;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_peak;
                        r_addr  <= r_peak;
                        r_state <= S_WK_RD;
                    end
                end
                S_WK_RD: r_state <= S_WK_MUL;
                S_WK_MUL: begin
                    r_bz    <= (rd_b == '0);
                    r_pl    <= PW'({rd_a, 16'b0});
                    r_pr    <= PW'(r_sens) * (PW'(rd_a) + PW'(rd_b));
                    r_state <= S_WK_CMP;
                end
                S_WK_CMP: begin
                    if (!r_right) begin
                        if (!pass) begin
                            r_begin <= (r_idx == r_peak) ? r_idx : r_idx + BW'(1);
                            r_state <= S_RW_START;
                        end else if (r_idx == BW'(1)) begin
                            r_begin <= '0;
                            r_state <= S_RW_START;
                        end else begin
                            r_idx   <= r_idx - BW'(1);
                            r_addr  <= r_idx - BW'(1);
                            r_state <= S_WK_RD;
                        end
                    end else begin
                        if (!pass) begin
                            r_end   <= (r_idx == r_peak) ? r_idx : r_idx - BW'(1);
                            r_state <= S_DONE;
                        end else if (r_idx + BW'(1) == r_hfb) begin
                            r_end   <= r_hfb;
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + BW'(1);
                            r_addr  <= r_idx + BW'(1);
                            r_state <= S_WK_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_begin   <= thrf_pkg::OUT_W'(r_begin);
                        r_o_end     <= thrf_pkg::OUT_W'(r_end);
                        r_o_peak    <= thrf_pkg::OUT_W'(r_peak);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_range_begin = r_o_begin;
    assign o_range_end   = r_o_end;
    assign o_peak_bin    = r_o_peak;

endmodule

// ===== rtl/thrf_checker.sv =====
// ----------------------------------------------------------------------------
// thrf_checker
// Port-level checks for the timing histogram hit-range finder.
// ----------------------------------------------------------------------------
module thrf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [thrf_pkg::OP_W-1:0]           i_opcode,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [thrf_pkg::OUT_W-1:0]          o_range_begin,
    input logic [thrf_pkg::OUT_W-1:0]          o_range_end,
    input logic [thrf_pkg::OUT_W-1:0]          o_peak_bin
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_init: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request taken during clearing pass");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_begin <= o_peak_bin) && (o_peak_bin <= o_range_end))
        else $error("range does not enclose peak");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken back to back");

    a_noresult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_opcode != thrf_pkg::OP_COMPUTE) |=> !$rose(o_valid))
        else $error("result from non-compute request");

endmodule

bind timing_histogram_hit_range_finder thrf_checker u_thrf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_opcode      (i_opcode),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_range_begin (o_range_begin),
    .o_range_end   (o_range_end),
    .o_peak_bin    (o_peak_bin)
);

// ===== sim/tb_timing_histogram_hit_range_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timing_histogram_hit_range_finder
// Self-checking bench for the hit-range finder. A directed table covers reset,
// the top bin and clears. Random sample, compute and clear requests follow,
// over several idling phases and sensitivity settings. A local model of both
// histograms predicts every range result that the table does not give.
// ----------------------------------------------------------------------------
module tb_timing_histogram_hit_range_finder;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 1300;
    localparam int COUNT_MAX      = (1 << thrf_pkg::COUNT_BITS) - 1;

    typedef struct packed {
        logic [thrf_pkg::OUT_W-1:0] range_begin;
        logic [thrf_pkg::OUT_W-1:0] range_end;
        logic [thrf_pkg::OUT_W-1:0] peak_bin;
    } t_range;

    typedef struct {
        thrf_pkg::t_opcode           op;
        logic [thrf_pkg::TIME_W-1:0] sample_time;
        bit                          typed;
        t_range                      result;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [thrf_pkg::OP_W-1:0]     i_opcode;
    logic [thrf_pkg::TIME_W-1:0]   i_sample_time;
    logic                          o_valid;
    logic                          i_ready;
    logic [thrf_pkg::OUT_W-1:0]    o_range_begin;
    logic [thrf_pkg::OUT_W-1:0]    o_range_end;
    logic [thrf_pkg::OUT_W-1:0]    o_peak_bin;
    logic                          i_cfg_wr_en;
    logic [thrf_pkg::SENS_W-1:0]   i_cfg_wr_data;

    int unsigned         hist_a [thrf_pkg::BIN_COUNT];
    int unsigned         hist_b [thrf_pkg::BIN_COUNT];
    int unsigned         top_filled;
    bit                  seen_sample;
    int unsigned         sens_model;

    t_range              pending_ranges [$];
    int                  mismatches;
    int                  idle_cycles;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    timing_histogram_hit_range_finder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_sample_time (i_sample_time),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_range_begin (o_range_begin),
        .o_range_end   (o_range_end),
        .o_peak_bin    (o_peak_bin),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void wipe_histograms();
        for (int i = 0; i < thrf_pkg::BIN_COUNT; i++) begin
            hist_a[i] = 0;
            hist_b[i] = 0;
        end
        top_filled  = 0;
        seen_sample = 1'b0;
    endfunction

    function automatic void record_sample(bit is_b, int unsigned t);
        int unsigned bin;
        bin = (t > thrf_pkg::BIN_COUNT - 1) ? thrf_pkg::BIN_COUNT - 1 : t;
        if (is_b) begin
            if (hist_b[bin] < COUNT_MAX) hist_b[bin]++;
        end else begin
            if (hist_a[bin] < COUNT_MAX) hist_a[bin]++;
        end
        if (!seen_sample || bin > top_filled) top_filled = bin;
        seen_sample = 1'b1;
    endfunction

    function automatic bit bin_in_range(int unsigned bin);
        longint unsigned a;
        longint unsigned b;
        a = 64'(hist_a[bin]);
        b = 64'(hist_b[bin]);
        if (b == 0) return 1'b1;
        return (a * 65536) >= (longint'(sens_model) * (a + b));
    endfunction

    function automatic t_range predict_range();
        longint unsigned best_a;
        longint unsigned best_b;
        int unsigned     peak;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     i;
        t_range          r;
        best_a = 0;
        best_b = 1;
        peak   = 0;
        for (i = 0; i < thrf_pkg::BIN_COUNT; i++) begin
            if (longint'(hist_a[i]) * best_b > best_a * longint'(hist_b[i])) begin
                best_a = 64'(hist_a[i]);
                best_b = 64'(hist_b[i]);
                peak   = i;
            end
        end
        lo = 0;
        for (i = peak; i > 0; i--) begin
            if (!bin_in_range(i)) begin
                lo = (i == peak) ? i : i + 1;
                break;
            end
        end
        for (i = peak; i < top_filled; i++) begin
            if (!bin_in_range(i)) break;
        end
        if (i < top_filled) hi = (i == peak) ? i : i - 1;
        else hi = i;
        r.range_begin = lo[thrf_pkg::OUT_W-1:0];
        r.range_end   = hi[thrf_pkg::OUT_W-1:0];
        r.peak_bin    = peak[thrf_pkg::OUT_W-1:0];
        return r;
    endfunction

    task automatic send_request(thrf_pkg::t_opcode op, logic [thrf_pkg::TIME_W-1:0] t,
                                bit typed, t_range typed_r);
        bit     took;
        t_range r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_sample_time <= t;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        case (op)
            thrf_pkg::OP_ADD_A:   record_sample(1'b0, 32'(t));
            thrf_pkg::OP_ADD_B:   record_sample(1'b1, 32'(t));
            thrf_pkg::OP_COMPUTE: begin
                r = predict_range();
                pending_ranges.push_back(typed ? typed_r : r);
            end
            default:    wipe_histograms();
        endcase
    endtask

    task automatic settle();
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sensitivity(int unsigned v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v[thrf_pkg::SENS_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sens_model = v;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int     pick;
        int     tsel;
        thrf_pkg::t_opcode op;
        logic [thrf_pkg::TIME_W-1:0] t;
        pick = $urandom_range(99);
        tsel = $urandom_range(99);
        if (pick < 3)       op = thrf_pkg::OP_COMPUTE;
        else if (pick < 5)  op = thrf_pkg::OP_CLEAR;
        else if (pick < 55) op = thrf_pkg::OP_ADD_A;
        else                op = thrf_pkg::OP_ADD_B;
        if (tsel < 75)      t = thrf_pkg::TIME_W'($urandom_range(31));
        else if (tsel < 88) t = thrf_pkg::TIME_W'($urandom_range(1023, 1000));
        else                t = thrf_pkg::TIME_W'($urandom_range(65535));
        send_request(op, t, 1'b0, '0);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge i_clk) begin
        t_range got;
        t_range want;
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_range_begin, o_range_end, o_peak_bin};
            if (pending_ranges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_ranges.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        int   sens_list [4];
        int   idle_list [4][2];
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = '0;
        i_sample_time  = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        i_ready        = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sens_model     = 32768;
        wipe_histograms();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'd0,    1'b1, '{10'd0, 10'd0, 10'd0}});
        rows.push_back('{thrf_pkg::OP_ADD_A,   16'd5,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'hFFFF, 1'b1, '{10'd0, 10'd5, 10'd5}});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'hFFFF, 1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_A,   16'd1023, 1'b0, '0});
        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'd0,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'd3,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'd3,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_A,   16'd3,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'd6,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_A,   16'd0,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'd0,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'd0,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_CLEAR,   16'hAAAA, 1'b0, '0});
        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'h5555, 1'b1, '{10'd0, 10'd0, 10'd0}});
        rows.push_back('{thrf_pkg::OP_ADD_A,   16'hFFFF, 1'b0, '0});
        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'd0,    1'b1,
                         '{10'd0, 10'd1023, 10'd1023}});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'd1024, 1'b0, '0});
        rows.push_back('{thrf_pkg::OP_ADD_B,   16'd2,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_COMPUTE, 16'd0,    1'b0, '0});
        rows.push_back('{thrf_pkg::OP_CLEAR,   16'd0,    1'b0, '0});
        foreach (rows[k]) send_request(rows[k].op, rows[k].sample_time, rows[k].typed,
                                       rows[k].result);
        i_valid <= 1'b0;
        settle();

        sens_list = '{32768, 0, 65536, 131071};
        idle_list = '{'{0, 0}, '{87, 0}, '{0, 87}, '{26, 26}};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 4) sens_list = '{$urandom_range(65535, 1), 65536, 0,
                                       $urandom_range(131071, 65537)};
            write_sensitivity(sens_list[ph % 4]);
            send_idle_pct  = idle_list[(ph + ph / 4) % 4][0];
            recv_stall_pct = idle_list[(ph + ph / 4) % 4][1];
            repeat (160) random_request();
            send_request(thrf_pkg::OP_COMPUTE, thrf_pkg::TIME_W'($urandom_range(65535)),
                         1'b0, '0);
            i_valid <= 1'b0;
            settle();
        end

        if (mismatches == 0 && pending_ranges.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/thrf_pkg.sv
rtl/timing_histogram_hit_range_finder.sv
rtl/thrf_checker.sv
sim/tb_timing_histogram_hit_range_finder.sv
